>>> sv/sust_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sust_pkg
// Shared types and codes for the sorted unique set table.
// ----------------------------------------------------------------------------
package sust_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp;   // latch the compare flags against the held value
    logic ins;   // shift up from the insertion point
    logic rem;   // shift down from the removal point
  } sust_ctl_t;

endpackage

>>> sv/sust_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sust_cell
// One entry of the sorted store with its own comparator and shift mux.
// ----------------------------------------------------------------------------
module sust_cell
  import sust_pkg::*;
(
  input  logic                    clk,
  input  sust_ctl_t               ctl,
  input  logic                    valid,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] left_elem,
  input  logic                    left_lt,
  input  logic signed [VAL_W-1:0] right_elem,
  output logic signed [VAL_W-1:0] elem,
  output logic                    lt,
  output logic                    eq
);

  logic lt_next;
  logic eq_next;

  assign lt_next = valid && (elem < value);
  assign eq_next = valid && (elem == value);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= lt_next;
      eq <= eq_next;
    end
  end

  // The entries below the target position keep their values; the target
  // and everything above it move one place along the chain.
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt) begin
      elem <= left_lt ? value : left_elem;
    end else if (ctl.rem && !lt) begin
      elem <= right_elem;
    end
  end

endmodule

>>> sv/sorted_unique_set_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_set_table_core
// Ordered set of distinct signed values held in a chain of compare cells.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid/in_ready    command[1:0], value[31:0] signed
//   out      out_valid/out_ready  ok, count[4:0]
//
// A request passes through acceptance, a compare state in which every
// cell registers its less-than and equal flags, and an update state in which
// the set shifts and the result is loaded into the output register.
// The output register frees the input side, so the next request is taken
// while a result waits; only the update cycle stalls on a full output.
// Reset empties the set at once; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_unique_set_table_core
  import sust_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
)
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              command,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    ok,
  output logic [COUNT_W-1:0]      count
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_t                  state;
  state_t                  state_next;
  cmd_t                    cmd_r;
  logic signed [VAL_W-1:0] val_r;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_next;
  logic                    ok_next;
  logic                    ins_ok;
  logic                    rem_ok;
  logic                    found;
  logic                    full;
  logic                    upd_fire;
  sust_ctl_t               ctl;

  logic signed [VAL_W-1:0] elem_vec [CAPACITY];
  logic [CAPACITY-1:0]     lt_vec;
  logic [CAPACITY-1:0]     eq_vec;
  logic [CAPACITY-1:0]     valid_vec;

  assign found    = |eq_vec;
  assign full     = (cnt == CNT_W'(CAPACITY));
  assign upd_fire = (state == S_UPD) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_CMP;
      S_CMP:  state_next = S_UPD;
      S_UPD:  if (upd_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Controls.
  always_comb begin
    in_ready = (state == S_IDLE);
    ctl.cmp  = (state == S_CMP);
    ctl.ins  = upd_fire && ins_ok;
    ctl.rem  = upd_fire && rem_ok;
  end

  // Command decode against the registered flags.
  always_comb begin
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    ok_next  = 1'b0;
    cnt_next = cnt;
    unique case (cmd_r)
      CMD_INSERT: begin
        ins_ok  = !full && !found;
        ok_next = ins_ok;
        if (ins_ok) cnt_next = cnt + CNT_W'(1);
      end
      CMD_REMOVE: begin
        rem_ok  = found;
        ok_next = found;
        if (found) cnt_next = cnt - CNT_W'(1);
      end
      CMD_QUERY: ok_next = found;
      CMD_CLEAR: begin
        ok_next  = 1'b1;
        cnt_next = '0;
      end
      default: ok_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (upd_fire) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_t'(command);
      val_r <= value;
    end
    if (upd_fire) begin
      ok    <= ok_next;
      count <= COUNT_W'(cnt_next);
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_elem;
      logic                    left_lt;
      logic signed [VAL_W-1:0] right_elem;

      assign valid_vec[i] = (CNT_W'(i) < cnt);

      if (i == 0) begin : g_first
        // The chain head takes the new value when nothing precedes it.
        assign left_elem = val_r;
        assign left_lt   = 1'b1;
      end else begin : g_mid
        assign left_elem = elem_vec[i-1];
        assign left_lt   = lt_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign right_elem = val_r;
      end else begin : g_inner
        assign right_elem = elem_vec[i+1];
      end

      sust_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .valid      (valid_vec[i]),
        .value      (val_r),
        .left_elem  (left_elem),
        .left_lt    (left_lt),
        .right_elem (right_elem),
        .elem       (elem_vec[i]),
        .lt         (lt_vec[i]),
        .eq         (eq_vec[i])
      );
    end
  endgenerate

endmodule

>>> tb/tb_sorted_unique_set_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_unique_set_table_core
// Self-checking bench for the ordered set table. A behavioral copy of the set
// predicts ok and count for every accepted request. A monitor compares each
// result, in order, against the oldest prediction. Directed cases cover the
// extreme values, duplicates, a full table and clears. Random traffic from a
// small value pool keeps the table near full under varying stall rates.
// ----------------------------------------------------------------------------
module tb_sorted_unique_set_table_core;
  import sust_pkg::*;

  localparam int unsigned CAPACITY    = 16;
  localparam int          HALF_PERIOD = 10;
  localparam int          RESET_CYCLES = 9;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_LIMIT = 20000;
  localparam int          POOL_SIZE   = 24;
  localparam int          MAX_REPORTS = 10;
  localparam longint      TIMEOUT_NS  = 10_000_000;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
  } set_result_t;

  localparam val_t MIN_VAL = 32'sh8000_0000;
  localparam val_t MAX_VAL = 32'sh7FFF_FFFF;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         command = CMD_QUERY;
  val_t               value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               ok;
  logic [COUNT_W-1:0] count;

  // Stall rates in percent, changed between test phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Back-pressure requests go from the test to the receiver by a counter.
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int mismatch_count = 0;

  val_t        set_contents[$];
  set_result_t expected_results[$];
  set_result_t predicted;
  set_result_t observed;

  sorted_unique_set_table_core #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .count     (count)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // Applies one request to the behavioral set and returns what the block
  // must answer.
  function automatic set_result_t apply_set_command(input cmd_t cmd, input val_t v);
    set_result_t res;
    int          pos;
    bit          hit;
    pos = 0;
    while (pos < set_contents.size() && set_contents[pos] < v) begin
      pos++;
    end
    hit = (pos < set_contents.size()) && (set_contents[pos] == v);
    case (cmd)
      CMD_INSERT: begin
        res.ok = !hit && (set_contents.size() < CAPACITY);
        if (res.ok) begin
          set_contents.insert(pos, v);
        end
      end
      CMD_REMOVE: begin
        res.ok = hit;
        if (hit) begin
          set_contents.delete(pos);
        end
      end
      CMD_QUERY: begin
        res.ok = hit;
      end
      default: begin
        set_contents.delete();
        res.ok = 1'b1;
      end
    endcase
    res.count = COUNT_W'(set_contents.size());
    return res;
  endfunction

  // Results are checked before the same edge's request is predicted, so the
  // oldest expectation is always the one at the front.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        observed = '{ok: ok, count: count};
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result ok=%0b count=%0d with nothing expected",
                                 observed.ok, observed.count));
        end else begin
          predicted = expected_results.pop_front();
          if (observed.ok !== predicted.ok) begin
            note_failure($sformatf("ok expected %0b, got %0b", predicted.ok, observed.ok));
          end
          if (observed.count !== predicted.count) begin
            note_failure($sformatf("count expected %0d, got %0d",
                                   predicted.count, observed.count));
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_set_command(cmd_t'(command), value));
      end
    end
  end

  // Receiver: random stalls, or a long hold when the test asks for one.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input cmd_t cmd, input val_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= v;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  function automatic val_t pick_pool_value();
    case ($urandom_range(2))
      0:       return val_t'($urandom);
      1:       return val_t'($urandom_range(40)) - 20;
      default: return $urandom_range(1) ? MIN_VAL + val_t'($urandom_range(5))
                                        : MAX_VAL - val_t'($urandom_range(5));
    endcase
  endfunction

  task automatic test_empty_set();
    send_request(CMD_QUERY, 32'sd7);
    send_request(CMD_REMOVE, 32'sd7);
  endtask

  task automatic test_extreme_values();
    send_request(CMD_INSERT, MIN_VAL);
    send_request(CMD_INSERT, MAX_VAL);
    send_request(CMD_INSERT, 32'sd0);
    send_request(CMD_INSERT, -32'sd1);
    send_request(CMD_INSERT, MAX_VAL);
    send_request(CMD_QUERY, MIN_VAL);
    send_request(CMD_QUERY, 32'sd5);
    send_request(CMD_REMOVE, 32'sd0);
  endtask

  // Three entries remain from the extreme-value test, so thirteen inserts
  // fill the table. Then a new value and a duplicate are both refused.
  task automatic test_full_table();
    for (int k = 1; k <= 13; k++) begin
      send_request(CMD_INSERT, val_t'(k * 1000));
    end
    send_request(CMD_INSERT, 32'sd99);
    send_request(CMD_INSERT, 32'sd1000);
  endtask

  task automatic test_clear_set();
    send_request(CMD_CLEAR, MAX_VAL);
    send_request(CMD_CLEAR, 32'sd0);
  endtask

  // Mostly pool values so that duplicates, hits and a full table are common;
  // some fully random values and commands add noise.
  task automatic test_random_traffic(input int n_items);
    val_t pool [POOL_SIZE];
    cmd_t cmd;
    val_t v;
    int   r;
    for (int i = 0; i < n_items; i++) begin
      if (i % 200 == 0) begin
        foreach (pool[j]) pool[j] = pick_pool_value();
      end
      r = $urandom_range(99);
      if (r < 45)      cmd = CMD_INSERT;
      else if (r < 70) cmd = CMD_REMOVE;
      else if (r < 97) cmd = CMD_QUERY;
      else             cmd = CMD_CLEAR;
      if ($urandom_range(99) < 85) v = pool[$urandom_range(POOL_SIZE - 1)];
      else                         v = val_t'($urandom);
      send_request(cmd, v);
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // block fills and drops in_ready.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    test_random_traffic(60);
  endtask

  initial begin
    int waited;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_empty_set();
    test_extreme_values();
    test_full_table();
    test_clear_set();
    test_output_backpressure();

    send_idle_pct = 37;
    recv_idle_pct = 47;
    test_random_traffic(520);
    send_idle_pct = 47;
    recv_idle_pct = 37;
    test_random_traffic(520);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(520);

    in_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    end

    if (mismatch_count == 0) begin
      $display("sorted_unique_set_table_core regression: pass");
    end else begin
      $display("sorted_unique_set_table_core regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("sorted_unique_set_table_core regression: fail");
    $finish;
  end

endmodule
